FILE: rtl/b128vc_pkg.sv
`default_nettype none

package b128vc_pkg;

    // field widths
    localparam int unsigned VALUE_W  = 64;
    localparam int unsigned OCTET_W  = 8;
    localparam int unsigned COUNT_W  = 8;
    localparam int unsigned STATUS_W = 2;

    // coding geometry
    localparam int unsigned GRP_W      = 7;
    localparam int unsigned MAX_GROUPS = (VALUE_W + GRP_W - 1) / GRP_W;
    localparam int unsigned IDX_W      = $clog2(MAX_GROUPS);
    localparam int unsigned EXT_W      = MAX_GROUPS * GRP_W;
    localparam int unsigned OVF_LSB    = VALUE_W - GRP_W;

    // command codes
    localparam logic CMD_DECODE = 1'b0;
    localparam logic CMD_ENCODE = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OCTET    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

    localparam logic [OCTET_W-1:0] CONT_BIT  = 8'h80;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hff;

    // controller to datapath
    typedef struct packed {
        logic dec_load;
        logic enc_load;
        logic enc_step;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic enc_single;
        logic enc_final;
    } sts_t;

    // 7-bit group at index idx, group 0 least significant
    function automatic logic [GRP_W-1:0] group_of(input logic [VALUE_W-1:0] v,
                                                  input logic [IDX_W-1:0] idx);
        logic [EXT_W-1:0] ve;
        logic [GRP_W-1:0] g;
        ve = {{(EXT_W - VALUE_W){1'b0}}, v};
        g  = '0;
        for (int k = 0; k < MAX_GROUPS; k++)
        begin
            if (idx == IDX_W'(k))
            begin
                g = ve[k*GRP_W +: GRP_W];
            end
        end
        return g;
    endfunction

    // index of the most significant nonzero group, 0 for small values
    function automatic logic [IDX_W-1:0] top_group(input logic [VALUE_W-1:0] v);
        logic [IDX_W-1:0] t;
        t = '0;
        for (int k = 1; k < MAX_GROUPS; k++)
        begin
            if ((v >> (k * GRP_W)) != '0)
            begin
                t = IDX_W'(k);
            end
        end
        return t;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/b128vc_req_if.sv
`default_nettype none

interface b128vc_req_if;
    logic                                valid;
    logic                                ready;
    logic                                cmd;
    logic [b128vc_pkg::OCTET_W-1:0]      octet_in;
    logic [b128vc_pkg::VALUE_W-1:0]      value_in;

    modport source (output valid, cmd, octet_in, value_in, input ready);
    modport sink   (input valid, cmd, octet_in, value_in, output ready);
endinterface

`default_nettype wire

FILE: rtl/b128vc_rsp_if.sv
`default_nettype none

interface b128vc_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [b128vc_pkg::STATUS_W-1:0]     status;
    logic [b128vc_pkg::OCTET_W-1:0]      octet_out;
    logic [b128vc_pkg::VALUE_W-1:0]      value_out;
    logic [b128vc_pkg::COUNT_W-1:0]      octet_count;
    logic                                last;

    modport source (output valid, status, octet_out, value_out, octet_count, last,
                    input ready);
    modport sink   (input valid, status, octet_out, value_out, octet_count, last,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/b128vc_ctrl.sv
`default_nettype none

module b128vc_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             in_cmd,
    output logic                  in_ready,
    input  wire b128vc_pkg::sts_t sts,
    output b128vc_pkg::cmd_t      cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_ENC  = 1'b1;

    logic state_reg;
    logic state_next;
    logic accept;

    // input side opens only when idle and the output register can take a result
    assign in_ready = (state_reg == S_IDLE) && sts.out_free;
    assign accept   = in_valid && in_ready;

    // datapath commands
    always_comb
    begin
        cmd.dec_load = accept && (in_cmd == b128vc_pkg::CMD_DECODE);
        cmd.enc_load = accept && (in_cmd == b128vc_pkg::CMD_ENCODE);
        cmd.enc_step = (state_reg == S_ENC) && sts.out_free;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.enc_load && !sts.enc_single)
                begin
                    state_next = S_ENC;
                end
            end
            S_ENC:
            begin
                if (cmd.enc_step && sts.enc_final)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/b128vc_dp.sv
`default_nettype none

module b128vc_dp (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire b128vc_pkg::cmd_t                   cmd,
    output b128vc_pkg::sts_t                        sts,
    input  wire logic [b128vc_pkg::OCTET_W-1:0]     octet_in,
    input  wire logic [b128vc_pkg::VALUE_W-1:0]     value_in,
    input  wire logic                               out_ready,
    output logic                                    out_valid,
    output logic [b128vc_pkg::STATUS_W-1:0]         out_status,
    output logic [b128vc_pkg::OCTET_W-1:0]          out_octet,
    output logic [b128vc_pkg::VALUE_W-1:0]          out_value,
    output logic [b128vc_pkg::COUNT_W-1:0]          out_count,
    output logic                                    out_last
);

    localparam int unsigned VW = b128vc_pkg::VALUE_W;
    localparam int unsigned OW = b128vc_pkg::OCTET_W;
    localparam int unsigned CW = b128vc_pkg::COUNT_W;
    localparam int unsigned SW = b128vc_pkg::STATUS_W;
    localparam int unsigned GW = b128vc_pkg::GRP_W;
    localparam int unsigned IW = b128vc_pkg::IDX_W;

    // decode state
    logic [VW-1:0] acc_reg,  acc_next;
    logic [CW-1:0] seen_reg, seen_next;

    // encode state
    logic [VW-1:0] enc_val_reg, enc_val_next;
    logic [IW-1:0] idx_reg,     idx_next;

    // output register
    logic          out_valid_reg,  out_valid_next;
    logic [SW-1:0] out_status_reg, out_status_next;
    logic [OW-1:0] out_octet_reg,  out_octet_next;
    logic [VW-1:0] out_value_reg,  out_value_next;
    logic [CW-1:0] out_count_reg,  out_count_next;
    logic          out_last_reg,   out_last_next;

    logic [VW-1:0] acc_shift;
    logic [CW-1:0] seen_inc;
    logic [IW-1:0] top_idx;
    logic [GW-1:0] first_grp;
    logic [GW-1:0] step_grp;

    // decode arithmetic
    assign acc_shift = (seen_reg == '0) ? VW'(octet_in[GW-1:0])
                                        : {acc_reg[VW-GW-1:0], octet_in[GW-1:0]};
    assign seen_inc  = (seen_reg == b128vc_pkg::COUNT_MAX) ? seen_reg : seen_reg + 1'b1;

    // encode group selection
    assign top_idx   = b128vc_pkg::top_group(value_in);
    assign first_grp = b128vc_pkg::group_of(value_in, top_idx);
    assign step_grp  = b128vc_pkg::group_of(enc_val_reg, idx_reg);

    // status to controller
    always_comb
    begin
        sts.out_free   = !out_valid_reg || out_ready;
        sts.enc_single = (top_idx == '0);
        sts.enc_final  = (idx_reg == '0);
    end

    always_comb
    begin
        acc_next        = acc_reg;
        seen_next       = seen_reg;
        enc_val_next    = enc_val_reg;
        idx_next        = idx_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_octet_next  = out_octet_reg;
        out_value_next  = out_value_reg;
        out_count_next  = out_count_reg;
        out_last_next   = out_last_reg;

        if (cmd.dec_load)
        begin
            if (!octet_in[OW-1])
            begin
                // final octet: report the integer
                out_valid_next  = 1'b1;
                out_status_next = b128vc_pkg::ST_DONE;
                out_octet_next  = '0;
                out_value_next  = acc_shift;
                out_count_next  = seen_inc;
                out_last_next   = 1'b1;
                acc_next        = '0;
                seen_next       = '0;
            end
            else if (acc_shift[VW-1:b128vc_pkg::OVF_LSB] != '0)
            begin
                // next shift would drop bits
                out_valid_next  = 1'b1;
                out_status_next = b128vc_pkg::ST_OVERFLOW;
                out_octet_next  = '0;
                out_value_next  = '0;
                out_count_next  = '0;
                out_last_next   = 1'b1;
                acc_next        = '0;
                seen_next       = '0;
            end
            else
            begin
                acc_next  = acc_shift;
                seen_next = seen_inc;
            end
        end
        else if (cmd.enc_load)
        begin
            // most significant group goes out with the transfer
            out_valid_next  = 1'b1;
            out_status_next = b128vc_pkg::ST_OCTET;
            out_value_next  = '0;
            out_count_next  = '0;
            out_last_next   = (top_idx == '0);
            out_octet_next  = (top_idx == '0) ? OW'(first_grp)
                                              : (OW'(first_grp) | b128vc_pkg::CONT_BIT);
            enc_val_next    = value_in;
            idx_next        = top_idx - 1'b1;
        end
        else if (cmd.enc_step)
        begin
            // one lower group per cycle while the output register is free
            out_valid_next  = 1'b1;
            out_status_next = b128vc_pkg::ST_OCTET;
            out_value_next  = '0;
            out_count_next  = '0;
            out_last_next   = (idx_reg == '0);
            out_octet_next  = (idx_reg == '0) ? OW'(step_grp)
                                              : (OW'(step_grp) | b128vc_pkg::CONT_BIT);
            idx_next        = idx_reg - 1'b1;
        end
    end

    // control and decode state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            seen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        enc_val_reg    <= enc_val_next;
        idx_reg        <= idx_next;
        out_status_reg <= out_status_next;
        out_octet_reg  <= out_octet_next;
        out_value_reg  <= out_value_next;
        out_count_reg  <= out_count_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_octet  = out_octet_reg;
    assign out_value  = out_value_reg;
    assign out_count  = out_count_reg;
    assign out_last   = out_last_reg;

    // no integer in progress means an empty accumulator
    a_idle_acc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (seen_reg == '0) |-> (acc_reg == '0))
        else $error("accumulator nonzero with no integer in progress");

    // a final octet always yields a completed integer
    a_final_done: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.dec_load && !octet_in[OW-1]) |=>
            (out_valid_reg && out_status_reg == b128vc_pkg::ST_DONE && out_count_reg != '0))
        else $error("final octet did not complete an integer");

    // continuation bit on encoded octets is the inverse of last
    a_cont_bit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == b128vc_pkg::ST_OCTET) |->
            (out_octet_reg[OW-1] != out_last_reg))
        else $error("continuation bit disagrees with last");

    // stepping never runs past the lowest group into a new load
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.enc_step && (cmd.enc_load || cmd.dec_load)))
        else $error("encode step overlaps an input transfer");

endmodule

`default_nettype wire

FILE: rtl/base128_varint_codec_core.sv
`default_nettype none

// Big-endian base-128 varint codec. A request with cmd 0 carries one octet to
// decode: octets with the top bit set build up the value, and the octet with
// the top bit clear yields one result with the value and octet count (count
// saturates at 255); a value that would exceed 64 bits yields one overflow
// result and the next octet starts a new integer. A request with cmd 1 carries
// a 64-bit value and yields its minimal coding of 1 to 10 octets, most
// significant first, one per cycle while the output register is free; the first
// octet is loaded at the request transfer, and the request side is held until
// the last octet is loaded, set by the single output octet register. Every
// request's final result carries last. Results sit in one output register, and
// a new request is taken in the same cycle that the pending result transfers.
// An encode does not disturb a decode in progress. No setup after reset.
module base128_varint_codec_core (
    input  wire logic     clk,
    input  wire logic     rst_n,
    b128vc_req_if.sink    req,
    b128vc_rsp_if.source  rsp
);

    b128vc_pkg::cmd_t cmd;
    b128vc_pkg::sts_t sts;

    b128vc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_cmd   (req.cmd),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    b128vc_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .octet_in   (req.octet_in),
        .value_in   (req.value_in),
        .out_ready  (rsp.ready),
        .out_valid  (rsp.valid),
        .out_status (rsp.status),
        .out_octet  (rsp.octet_out),
        .out_value  (rsp.value_out),
        .out_count  (rsp.octet_count),
        .out_last   (rsp.last)
    );

endmodule

`default_nettype wire
